// ===== rtl/blrc_pkg.sv =====
// Shared widths, operation codes, register map and sequencer states for the array list.
package blrc_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CAP_W   = 9;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Register index, taken from paddr[2] (one register per 4-byte word).
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_FIND   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

// ===== rtl/blrc_if.sv =====
// Request and response channel interfaces of the array list.
interface blrc_req_if;
    logic                              valid;
    logic                              ready;
    logic [blrc_pkg::FUNC_W-1:0]       func;
    logic signed [blrc_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface blrc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic                         found;
    logic [blrc_pkg::COUNT_W-1:0] count;
    logic                         full_res;
    logic                         empty_res;

    modport source (output valid, output ok, output found, output count,
                    output full_res, output empty_res, input ready);
    modport sink (input valid, input ok, input found, input count,
                  input full_res, input empty_res, output ready);
endinterface

// ===== rtl/bounded_list_remove_compact.sv =====
// Bounded array list with add, remove-all-copies with compaction, and find.
// Each item walks its stored entries in ST_SCAN, then loads its result in ST_FINISH.
// No new item is taken until the last result is loaded; the memory walk sets the pace.
// Every operation scans all stored entries once through the single read port and comparator.
// Reset (rst_n, asynchronous, active low) empties the list and sets capacity to 256.
// The entry memory is not cleared: only positions below the count are ever read.
module bounded_list_remove_compact #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blrc_pkg::PADDR_W-1:0]  paddr,
    input  logic [blrc_pkg::PDATA_W-1:0]  pwdata,
    output logic [blrc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // item channels
    blrc_req_if.sink                      req,
    blrc_rsp_if.source                    rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = blrc_pkg::COUNT_W;

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    blrc_pkg::state_t                    state_reg, state_next;
    logic [blrc_pkg::FUNC_W-1:0]         func_reg;
    logic [blrc_pkg::VALUE_W-1:0]        word_reg;
    logic [CW-1:0]                       count_reg, count_next;
    logic [blrc_pkg::CAP_W-1:0]          cap_reg;
    logic [CW-1:0]                       issue_reg;  // next entry to read
    logic [CW-1:0]                       wr_reg;     // compaction write pointer
    logic                                pend_reg;   // read data valid this cycle
    logic                                found_reg;

    logic                                rsp_valid_reg;
    logic                                rsp_ok_reg;
    logic                                rsp_found_reg;
    logic [CW-1:0]                       rsp_count_reg;
    logic                                rsp_full_reg;
    logic                                rsp_empty_reg;

    // Entry memory: one read and one write port, read data registered
    logic [blrc_pkg::VALUE_W-1:0]        mem [MAX_ENTRIES];
    logic [blrc_pkg::VALUE_W-1:0]        mem_rdata;
    logic                                mem_re;
    logic [AW-1:0]                       mem_raddr;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [blrc_pkg::VALUE_W-1:0]        mem_wdata;

    logic [CW-1:0]                       cap_eff;
    logic                                in_accept;
    logic                                cfg_write;
    logic                                more_to_read;
    logic                                match;
    logic                                is_remove;
    logic                                add_ok;
    logic                                out_load;
    logic                                ok_next;

    // ------------------------------------------------------------------
    // Configuration port: zero wait states, capacity is the only register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == blrc_pkg::REG_CAPACITY);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == blrc_pkg::REG_CAPACITY)
        begin
            prdata = {{(blrc_pkg::PDATA_W - blrc_pkg::CAP_W){1'b0}}, cap_reg};
        end
    end

    // Saturate capacity to the physical depth
    always_comb
    begin
        if (32'(cap_reg) > MAX_ENTRIES)
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer datapath
    // ------------------------------------------------------------------
    assign in_accept    = req.valid && req.ready;
    assign req.ready    = (state_reg == blrc_pkg::ST_IDLE);
    assign is_remove    = (func_reg == blrc_pkg::FN_REMOVE);
    assign more_to_read = (issue_reg < count_reg);

    // The one shared comparator: stored word against the item's word
    assign match = pend_reg && (mem_rdata == word_reg);

    assign add_ok   = (count_reg < cap_eff);
    assign out_load = (state_reg == blrc_pkg::ST_FINISH) && (!rsp_valid_reg || rsp.ready);

    // Read the next stored entry while scanning
    assign mem_re    = (state_reg == blrc_pkg::ST_SCAN) && more_to_read;
    assign mem_raddr = AW'(issue_reg);

    // Write port: compaction during the scan, append when an add completes
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(wr_reg);
        mem_wdata = mem_rdata;
        if ((state_reg == blrc_pkg::ST_SCAN) && pend_reg && !match && is_remove)
        begin
            mem_we = 1'b1;
        end
        else if (out_load && (func_reg == blrc_pkg::FN_ADD) && add_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_reg);
            mem_wdata = word_reg;
        end
    end

    // Count and success flag once the scan is over. After a remove the
    // write pointer holds the survivors; with no match it equals the count.
    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        case (func_reg)
            blrc_pkg::FN_ADD:
            begin
                ok_next = add_ok;
                if (add_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            blrc_pkg::FN_REMOVE:
            begin
                ok_next    = found_reg;
                count_next = wr_reg;
            end
            blrc_pkg::FN_FIND:
            begin
                ok_next = found_reg;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // State transitions
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blrc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = blrc_pkg::ST_SCAN;
                end
            end
            blrc_pkg::ST_SCAN:
            begin
                // last comparison completes this cycle
                if (!more_to_read)
                begin
                    state_next = blrc_pkg::ST_FINISH;
                end
            end
            blrc_pkg::ST_FINISH:
            begin
                // hold until the response register is free
                if (out_load)
                begin
                    state_next = blrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blrc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blrc_pkg::ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= blrc_pkg::CAP_RESET;
            issue_reg     <= '0;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                cap_reg <= pwdata[blrc_pkg::CAP_W-1:0];
            end

            if (in_accept)
            begin
                issue_reg <= '0;
                wr_reg    <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (state_reg == blrc_pkg::ST_SCAN)
            begin
                pend_reg <= more_to_read;
                if (more_to_read)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                else if (pend_reg)
                begin
                    // advance past a surviving entry
                    wr_reg <= wr_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload and response payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= req.func;
            word_reg <= req.value;
        end
        if (out_load)
        begin
            rsp_ok_reg    <= ok_next;
            rsp_found_reg <= found_reg;
            rsp_count_reg <= count_next;
            rsp_full_reg  <= (count_next >= cap_eff);
            rsp_empty_reg <= (count_next == '0);
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = rsp_ok_reg;
    assign rsp.found     = rsp_found_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.full_res  = rsp_full_reg;
    assign rsp.empty_res = rsp_empty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_ENTRIES)
        else $error("entry count beyond memory depth");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == blrc_pkg::ST_SCAN) |-> (wr_reg <= issue_reg))
        else $error("compaction pointer overtook read pointer");

    a_count_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(count_reg))
        else $error("count changed outside result load");

    a_rsp_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (rsp.valid && (rsp.count == count_reg)))
        else $error("response count disagrees with stored count");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == blrc_pkg::ST_SCAN) && !pend_reg && (issue_reg == '0))
        else $error("accepted item did not start a fresh scan");

endmodule

// ===== tb/bounded_list_remove_compact_tb.sv =====
// Self-checking testbench for the bounded array list: directed cases, then random phases.
module bounded_list_remove_compact_tb;

    // Depth of the list under test, matching the block's default.
    localparam int unsigned LIST_DEPTH = 256;
    // Cycles with no handshake at all before the run is declared hung.
    localparam int unsigned IDLE_LIMIT = 3000;
    // Operation code the block does not define.
    localparam logic [blrc_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
    // Byte addresses of register index 0 (capacity) and index 1 (nothing there).
    localparam logic [blrc_pkg::PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [blrc_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic                         ok;
        logic                         found;
        logic [blrc_pkg::COUNT_W-1:0] count;
        logic                         full_res;
        logic                         empty_res;
    } list_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [blrc_pkg::PADDR_W-1:0] paddr;
    logic [blrc_pkg::PDATA_W-1:0] pwdata;
    logic [blrc_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    blrc_req_if req_ch();
    blrc_rsp_if rsp_ch();

    bounded_list_remove_compact #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Mirror of the list contents and of the capacity register.
    logic [blrc_pkg::VALUE_W-1:0] mirror_words[$];
    logic [blrc_pkg::CAP_W-1:0]   mirror_capacity;
    // Results still owed by the block, oldest first.
    list_result_t                 owed_results[$];
    list_result_t                 oldest_owed;

    int unsigned                  error_count = 0;
    int unsigned                  idle_cycles = 0;
    int unsigned                  burst_left = 0;
    int unsigned                  stall_mode = 0;
    int unsigned                  stall_mode_left = 0;
    int unsigned                  stall_left = 0;
    // Small set of words per phase, so that hits and duplicates are common.
    logic [blrc_pkg::VALUE_W-1:0] word_pool[8];

    // Clock: period of 2 time units.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the result of one operation and advance the mirror.
    function automatic list_result_t predict_list_op(
        input logic [blrc_pkg::FUNC_W-1:0]  fn,
        input logic [blrc_pkg::VALUE_W-1:0] word);
        list_result_t                 res;
        logic [blrc_pkg::VALUE_W-1:0] kept[$];
        int unsigned                  limit;
        int unsigned                  n;
        logic                         hit;
        // Capacity above the list depth saturates.
        limit = (mirror_capacity > LIST_DEPTH) ? LIST_DEPTH : mirror_capacity;
        hit = 1'b0;
        foreach (mirror_words[i])
        begin
            if (mirror_words[i] == word)
                hit = 1'b1;
        end
        res.ok = 1'b0;
        case (fn)
            blrc_pkg::FN_ADD:
            begin
                // Refuse once the count has reached the capacity, even a lowered one.
                if (mirror_words.size() < limit)
                begin
                    mirror_words.push_back(word);
                    res.ok = 1'b1;
                end
            end
            blrc_pkg::FN_REMOVE:
            begin
                // Drop every copy and close the gaps in order; an empty list never hits.
                if (hit)
                begin
                    foreach (mirror_words[i])
                    begin
                        if (mirror_words[i] != word)
                            kept.push_back(mirror_words[i]);
                    end
                    mirror_words = kept;
                    res.ok = 1'b1;
                end
            end
            blrc_pkg::FN_FIND:
                res.ok = hit;
            default:
                ;
        endcase
        // The found flag reports the state before the operation, for every code.
        n             = mirror_words.size();
        res.found     = hit;
        res.count     = n[blrc_pkg::COUNT_W-1:0];
        res.full_res  = (n >= limit);
        res.empty_res = (n == 0);
        return res;
    endfunction

    // Send one item; the sender runs in bursts with random gaps between them.
    // Call and return at a falling edge; valid is left high for a following item.
    task automatic send_item(input logic [blrc_pkg::FUNC_W-1:0] fn,
                             input logic [blrc_pkg::VALUE_W-1:0] word);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 9);
            if (gap != 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_ch.valid = 1'b1;
        req_ch.func  = fn;
        req_ch.value = word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        owed_results.push_back(predict_list_op(fn, word));
        burst_left--;
        @(negedge clk);
    endtask

    // Hold the sender until every owed result has come, then let the block settle.
    task automatic wait_list_idle();
        req_ch.valid = 1'b0;
        burst_left = 0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle. Call only while idle.
    task automatic write_reg(input logic [blrc_pkg::PADDR_W-1:0] addr,
                             input logic [blrc_pkg::PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Only index 0 exists; a write to any other index is dropped.
        if (addr[2] == blrc_pkg::REG_CAPACITY)
            mirror_capacity = data[blrc_pkg::CAP_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Draw a word: mostly from the pool, sometimes a stored one, sometimes anything.
    function automatic logic [blrc_pkg::VALUE_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return word_pool[$urandom_range(0, 7)];
        if (r < 8 && mirror_words.size() != 0)
            return mirror_words[$urandom_range(0, mirror_words.size() - 1)];
        return $urandom;
    endfunction

    // Draw an operation: add_pct percent adds, the rest split between remove and
    // find, with a few unused codes.
    function automatic logic [blrc_pkg::FUNC_W-1:0] pick_func(input int unsigned add_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return blrc_pkg::FN_ADD;
        if (r < add_pct + (95 - add_pct) / 2)
            return blrc_pkg::FN_REMOVE;
        if (r < 95)
            return blrc_pkg::FN_FIND;
        return FN_UNUSED;
    endfunction

    // ---------------------------------------------------------------- tests

    // Find and remove on the list just out of reset.
    task automatic test_empty_list();
        send_item(blrc_pkg::FN_FIND, 32'h0000_0000);
        send_item(blrc_pkg::FN_REMOVE, 32'h7FFF_FFFF);
    endtask

    // Store the extreme words, one of them twice, and look up one of them and an absent word.
    task automatic test_add_and_find_extremes();
        send_item(blrc_pkg::FN_ADD, 32'h8000_0000);
        send_item(blrc_pkg::FN_ADD, 32'h7FFF_FFFF);
        send_item(blrc_pkg::FN_ADD, 32'h0000_0000);
        send_item(blrc_pkg::FN_ADD, 32'hFFFF_FFFF);
        send_item(blrc_pkg::FN_ADD, 32'h7FFF_FFFF);
        send_item(blrc_pkg::FN_FIND, 32'h8000_0000);
        send_item(blrc_pkg::FN_FIND, 32'h0000_0001);
    endtask

    // Remove both copies with compaction, then miss on the same word and on an absent one.
    task automatic test_remove_all_copies();
        send_item(blrc_pkg::FN_REMOVE, 32'h7FFF_FFFF);
        send_item(blrc_pkg::FN_FIND, 32'h7FFF_FFFF);
        send_item(blrc_pkg::FN_REMOVE, 32'h1234_5678);
    endtask

    // The undefined code changes nothing, whether the word is stored or not.
    task automatic test_unused_code();
        send_item(FN_UNUSED, 32'h0000_0000);
        send_item(FN_UNUSED, 32'h0000_0037);
    endtask

    // Lower the capacity below the count: entries stay, adds fail, full is set.
    task automatic test_capacity_below_count();
        wait_list_idle();
        write_reg(ADDR_CAPACITY, 32'd2);
        send_item(blrc_pkg::FN_ADD, 32'h0000_0005);
        send_item(blrc_pkg::FN_FIND, 32'hFFFF_FFFF);
        send_item(blrc_pkg::FN_REMOVE, 32'h0000_0000);
        send_item(blrc_pkg::FN_REMOVE, 32'hFFFF_FFFF);
    endtask

    // A write to the unmapped index must leave the capacity alone.
    task automatic test_unmapped_register();
        wait_list_idle();
        write_reg(ADDR_UNMAPPED, 32'd0);
        send_item(blrc_pkg::FN_ADD, 32'h0000_0009);
    endtask

    // Empty the list, then zero capacity: full and empty at once, adds fail.
    task automatic test_capacity_zero();
        send_item(blrc_pkg::FN_REMOVE, 32'h8000_0000);
        send_item(blrc_pkg::FN_REMOVE, 32'h0000_0009);
        wait_list_idle();
        // Upper data bits set: only the low nine bits reach the register.
        write_reg(ADDR_CAPACITY, 32'hFFFF_FE00);
        send_item(blrc_pkg::FN_ADD, 32'h0000_0001);
    endtask

    // The largest register value saturates to the list depth.
    task automatic test_capacity_saturates();
        wait_list_idle();
        write_reg(ADDR_CAPACITY, 32'hFFFF_FFFF);
        send_item(blrc_pkg::FN_ADD, 32'h0000_0003);
        send_item(blrc_pkg::FN_REMOVE, 32'h0000_0003);
    endtask

    // One random phase: settle, set the capacity, refresh the pool, then stream items.
    task automatic run_random_phase(input logic [blrc_pkg::PDATA_W-1:0] cap_data,
                                    input int unsigned items,
                                    input int unsigned add_pct);
        wait_list_idle();
        write_reg(ADDR_CAPACITY, cap_data);
        word_pool[0] = 32'h8000_0000;
        word_pool[1] = 32'h7FFF_FFFF;
        word_pool[2] = $urandom_range(0, 3);
        word_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            word_pool[i] = $urandom;
        repeat (items)
            send_item(pick_func(add_pct), pick_word());
    endtask

    // Random phases over several capacities, the extremes among them.
    task automatic test_random_traffic();
        run_random_phase(32'd4, 250, 45);
        run_random_phase(32'd1, 100, 45);
        run_random_phase(32'd16, 300, 50);
        run_random_phase(32'd0, 100, 30);
        // Fill to the full depth, then keep pushing against it.
        run_random_phase(32'd256, 320, 85);
        // Capacity far below the count left by the fill; drain it mostly by removes.
        run_random_phase(32'd8, 150, 20);
        run_random_phase(($urandom & 32'hFFFF_FE00) | $urandom_range(1, 32), 230, 45);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.func  = blrc_pkg::FN_ADD;
        req_ch.value = '0;
        mirror_words.delete();
        mirror_capacity = blrc_pkg::CAP_RESET;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_add_and_find_extremes();
        test_remove_all_copies();
        test_unused_code();
        test_capacity_below_count();
        test_unmapped_register();
        test_capacity_zero();
        test_capacity_saturates();
        test_random_traffic();

        // Wait for the last results, then give any stray one time to show.
        wait_list_idle();
        repeat (LIST_DEPTH + 8) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: switch between always ready, coin-toss ready and long stalls.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_mode_left = $urandom_range(20, 300);
            end
            stall_mode_left--;
            case (stall_mode)
                0:
                    rsp_ch.ready = 1'b1;
                1:
                    rsp_ch.ready = $urandom_range(0, 1);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        rsp_ch.ready = 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        rsp_ch.ready = 1'b1;
                        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
                    end
                end
            endcase
        end
    end

    // Compare one field and count a mismatch.
    task automatic check_field(input string field,
                               input logic [blrc_pkg::COUNT_W-1:0] want,
                               input logic [blrc_pkg::COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // Check each accepted result against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result accepted with none owed");
                error_count++;
            end
            else
            begin
                oldest_owed = owed_results.pop_front();
                check_field("ok", oldest_owed.ok, rsp_ch.ok);
                check_field("found", oldest_owed.found, rsp_ch.found);
                check_field("count", oldest_owed.count, rsp_ch.count);
                check_field("full_res", oldest_owed.full_res, rsp_ch.full_res);
                check_field("empty_res", oldest_owed.empty_res, rsp_ch.empty_res);
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
